// ===== src/tfc_pkg.sv =====
`timescale 1ns / 1ps

package tfc_pkg;

  localparam int unsigned POS_W = 9;

  // Fixed byte positions within a frame
  localparam logic [POS_W-1:0] POS_HEADER    = 9'd0;
  localparam logic [POS_W-1:0] POS_LENGTH    = 9'd1;
  localparam logic [POS_W-1:0] POS_SEQUENCE  = 9'd2;
  localparam logic [POS_W-1:0] POS_SYSTEM    = 9'd3;
  localparam logic [POS_W-1:0] POS_COMPONENT = 9'd4;
  localparam logic [POS_W-1:0] POS_MESSAGE   = 9'd5;
  localparam logic [POS_W-1:0] POS_PAYLOAD   = 9'd6;
  // Longest frame: header fields, 255 payload bytes, two checksum bytes
  localparam logic [POS_W-1:0] POS_LAST      = 9'd262;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Result kinds
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // Configuration register indexes
  localparam logic CFG_EXTRA_ENABLE = 1'b0;
  localparam logic CFG_EXTRA_VALUE  = 1'b1;

  // X.25 CRC-16, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [7:0] t;
    t = data ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// ===== src/telemetry_frame_checker.sv =====
`timescale 1ns / 1ps
// A result item appears on the output register in the cycle after the byte that
//   causes it is accepted.
// Throughput: one byte per cycle unless a pending result waits on out_ready; the CRC
//   update is one byte-wide XOR network; the output register reloads as it drains.
// Reset (rst, synchronous): frame position back to header, CRC to 0xFFFF, captured
//   fields to zero, extra_byte_enable to 1, extra_byte_value to 0, no result pending.
module telemetry_frame_checker (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  // result items out
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [7:0]  header_byte,
  output logic [7:0]  frame_length,
  output logic [7:0]  sequence_number,
  output logic [7:0]  system_id,
  output logic [7:0]  component_id,
  output logic [7:0]  message_id,
  output logic        checksum_ok,
  output logic [15:0] received_checksum,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  // Configuration registers
  logic       extra_byte_enable;
  logic [7:0] extra_byte_value;

  // Frame parsing state
  logic [tfc_pkg::POS_W-1:0] frame_position;
  logic [tfc_pkg::POS_W-1:0] frame_position_next;
  logic [15:0] crc_accumulator;
  logic [15:0] crc_accumulator_next;
  logic [7:0]  held_header;
  logic [7:0]  held_length;
  logic [7:0]  held_sequence;
  logic [7:0]  held_system;
  logic [7:0]  held_component;
  logic [7:0]  held_message;
  logic [7:0]  checksum_low_byte;

  logic accept;
  logic in_header;       // positions 0..5
  logic in_payload;      // payload bytes
  logic at_crc_low;      // first checksum byte
  logic at_frame_end;    // second checksum byte
  logic emit;

  logic [tfc_pkg::POS_W-1:0] pay_end;
  logic [15:0] crc_data;     // CRC with the current byte folded in
  logic [15:0] crc_final;    // CRC at frame end, with optional extra byte
  logic [15:0] rx_checksum;

  // The output register frees up as it drains, so a byte can come in every cycle while
  // out_ready is high, even while a result sits waiting.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign pay_end      = tfc_pkg::POS_PAYLOAD + {1'b0, held_length};
  assign in_header    = frame_position < tfc_pkg::POS_PAYLOAD;
  assign in_payload   = !in_header && (frame_position < pay_end);
  assign at_crc_low   = frame_position == pay_end;
  assign at_frame_end = !in_header && (frame_position > pay_end);
  assign emit         = in_payload || at_frame_end;

  assign crc_data    = tfc_pkg::crc_feed(crc_accumulator, data_byte);
  assign crc_final   = extra_byte_enable ? tfc_pkg::crc_feed(crc_accumulator, extra_byte_value)
                                         : crc_accumulator;
  assign rx_checksum = {data_byte, checksum_low_byte};

  // Position and CRC advance
  always_comb begin
    frame_position_next  = frame_position + 9'd1;
    crc_accumulator_next = crc_accumulator;
    if (frame_position == tfc_pkg::POS_HEADER) begin
      // header restarts the checksum, but is not folded into it
      crc_accumulator_next = tfc_pkg::CRC_INIT;
    end else if (in_header || in_payload) begin
      crc_accumulator_next = crc_data;
    end else if (at_frame_end) begin
      frame_position_next  = tfc_pkg::POS_HEADER;
      crc_accumulator_next = tfc_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_byte_enable <= 1'b1;
      extra_byte_value  <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_index)
        tfc_pkg::CFG_EXTRA_ENABLE: extra_byte_enable <= cfg_data[0];
        tfc_pkg::CFG_EXTRA_VALUE:  extra_byte_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position    <= tfc_pkg::POS_HEADER;
      crc_accumulator   <= tfc_pkg::CRC_INIT;
      held_header       <= 8'h00;
      held_length       <= 8'h00;
      held_sequence     <= 8'h00;
      held_system       <= 8'h00;
      held_component    <= 8'h00;
      held_message      <= 8'h00;
      checksum_low_byte <= 8'h00;
    end else if (accept) begin
      frame_position  <= frame_position_next;
      crc_accumulator <= crc_accumulator_next;
      case (frame_position)
        tfc_pkg::POS_HEADER:    held_header    <= data_byte;
        tfc_pkg::POS_LENGTH:    held_length    <= data_byte;
        tfc_pkg::POS_SEQUENCE:  held_sequence  <= data_byte;
        tfc_pkg::POS_SYSTEM:    held_system    <= data_byte;
        tfc_pkg::POS_COMPONENT: held_component <= data_byte;
        tfc_pkg::POS_MESSAGE:   held_message   <= data_byte;
        default: begin
          if (at_crc_low) begin
            checksum_low_byte <= data_byte;
          end
        end
      endcase
    end
  end

  // Output register: valid is control, the rest is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      if (in_payload) begin
        result_kind       <= tfc_pkg::KIND_PAYLOAD;
        payload_byte      <= data_byte;
        payload_index     <= 8'(frame_position - tfc_pkg::POS_PAYLOAD);
        header_byte       <= 8'h00;
        frame_length      <= 8'h00;
        sequence_number   <= 8'h00;
        system_id         <= 8'h00;
        component_id      <= 8'h00;
        message_id        <= 8'h00;
        checksum_ok       <= 1'b0;
        received_checksum <= 16'h0000;
      end else begin
        result_kind       <= tfc_pkg::KIND_FRAME_END;
        payload_byte      <= 8'h00;
        payload_index     <= 8'h00;
        header_byte       <= held_header;
        frame_length      <= held_length;
        sequence_number   <= held_sequence;
        system_id         <= held_system;
        component_id      <= held_component;
        message_id        <= held_message;
        checksum_ok       <= rx_checksum == crc_final;
        received_checksum <= rx_checksum;
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    frame_position <= tfc_pkg::POS_LAST)
    else $error("frame position past longest frame");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_frame_end_restart: assert property (@(posedge clk) disable iff (rst)
    accept && at_frame_end |=> frame_position == tfc_pkg::POS_HEADER &&
                               crc_accumulator == tfc_pkg::CRC_INIT)
    else $error("frame end did not restart the parser");

  a_end_result_emitted: assert property (@(posedge clk) disable iff (rst)
    accept && at_frame_end |=> out_valid && result_kind == tfc_pkg::KIND_FRAME_END)
    else $error("frame end result missing");

  a_payload_index_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == tfc_pkg::KIND_PAYLOAD |-> payload_index < frame_length ||
                                                          header_byte == 8'h00)
    else $error("payload result carries header fields");
`endif

endmodule

// ===== test/tfc_result_checker.sv =====
`timescale 1ns / 1ps

package tfc_tb_pkg;

  // One result item as seen on the output channel
  typedef struct packed {
    logic        kind;
    logic [7:0]  pay_byte;
    logic [7:0]  pay_index;
    logic [7:0]  header;
    logic [7:0]  frame_len;
    logic [7:0]  seq_num;
    logic [7:0]  sys_id;
    logic [7:0]  comp_id;
    logic [7:0]  msg_id;
    logic        sum_ok;
    logic [15:0] rx_sum;
  } frame_result_t;

  // Bitwise reflected CRC-16, poly 0x8408 (X.25 update, one byte)
  function automatic logic [15:0] x25_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
    end
    return r;
  endfunction

endpackage

module tfc_result_checker
  import tfc_pkg::*;
  import tfc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        result_kind,
  input  logic [7:0]  payload_byte,
  input  logic [7:0]  payload_index,
  input  logic [7:0]  header_byte,
  input  logic [7:0]  frame_length,
  input  logic [7:0]  sequence_number,
  input  logic [7:0]  system_id,
  input  logic [7:0]  component_id,
  input  logic [7:0]  message_id,
  input  logic        checksum_ok,
  input  logic [15:0] received_checksum,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          payload_checked,
  output int          frames_checked
);

  frame_result_t expected_results[$];

  logic        extra_en;
  logic [7:0]  extra_val;
  int unsigned parse_pos;
  logic [15:0] crc_acc;
  logic [7:0]  hdr_q, len_q, seq_q, sys_q, comp_q, msg_q, sum_lo_q;

  function automatic string describe(input frame_result_t r);
    return $sformatf({"kind=%0d byte=%02h idx=%0d hdr=%02h len=%0d seq=%02h sys=%02h ",
                      "comp=%02h msg=%02h ok=%0d sum=%04h"},
                     r.kind, r.pay_byte, r.pay_index, r.header, r.frame_len, r.seq_num,
                     r.sys_id, r.comp_id, r.msg_id, r.sum_ok, r.rx_sum);
  endfunction

  // Advance the frame parser by one byte; queue whatever result it yields
  task automatic parse_stream_byte(input logic [7:0] b);
    frame_result_t r;
    logic [15:0]   closing_crc;
    r = '0;
    if (parse_pos < POS_PAYLOAD) begin
      case (parse_pos)
        POS_HEADER: begin
          hdr_q   = b;
          crc_acc = CRC_INIT;
        end
        POS_LENGTH:    len_q  = b;
        POS_SEQUENCE:  seq_q  = b;
        POS_SYSTEM:    sys_q  = b;
        POS_COMPONENT: comp_q = b;
        default:       msg_q  = b;
      endcase
      if (parse_pos != POS_HEADER) crc_acc = x25_next(crc_acc, b);
      parse_pos++;
    end else if (parse_pos < POS_PAYLOAD + len_q) begin
      crc_acc     = x25_next(crc_acc, b);
      r.kind      = KIND_PAYLOAD;
      r.pay_byte  = b;
      r.pay_index = 8'(parse_pos - POS_PAYLOAD);
      expected_results.push_back(r);
      parse_pos++;
    end else if (parse_pos == POS_PAYLOAD + len_q) begin
      sum_lo_q = b;
      parse_pos++;
    end else begin
      // registers are sampled here, at frame end
      closing_crc = crc_acc;
      if (extra_en) closing_crc = x25_next(closing_crc, extra_val);
      r.kind      = KIND_FRAME_END;
      r.header    = hdr_q;
      r.frame_len = len_q;
      r.seq_num   = seq_q;
      r.sys_id    = sys_q;
      r.comp_id   = comp_q;
      r.msg_id    = msg_q;
      r.rx_sum    = {b, sum_lo_q};
      r.sum_ok    = (r.rx_sum == closing_crc);
      expected_results.push_back(r);
      parse_pos = POS_HEADER;
      crc_acc   = CRC_INIT;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t got, want;
    if (rst) begin
      expected_results.delete();
      extra_en  = 1'b1;
      extra_val = 8'h00;
      parse_pos = POS_HEADER;
      crc_acc   = CRC_INIT;
      {hdr_q, len_q, seq_q, sys_q, comp_q, msg_q, sum_lo_q} = '0;
    end else begin
      if (out_valid && out_ready) begin
        got = {result_kind, payload_byte, payload_index, header_byte, frame_length,
               sequence_number, system_id, component_id, message_id, checksum_ok,
               received_checksum};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result item: %s", describe(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result item mismatch at %0t", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
          if (want.kind == KIND_FRAME_END) frames_checked++;
          else payload_checked++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_EXTRA_ENABLE) extra_en = cfg_data[0];
        else extra_val = cfg_data;
      end
      if (in_valid && in_ready) parse_stream_byte(data_byte);
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== test/tb_telemetry_frame_checker.sv =====
`timescale 1ns / 1ps

module tb_telemetry_frame_checker;
  import tfc_pkg::*;

  localparam int RANDOM_BYTES    = 1750;
  localparam int DRAIN_PAD       = 4;        // result shows up in the cycle after its byte
  localparam int HOLD_OFF_CYCLES = 400;      // long receiver stall, fills the block
  localparam int WATCHDOG_NS     = 5000000;  // timeout in ns, several times the slow case

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  header_byte;
  logic [7:0]  frame_length;
  logic [7:0]  sequence_number;
  logic [7:0]  system_id;
  logic [7:0]  component_id;
  logic [7:0]  message_id;
  logic        checksum_ok;
  logic [15:0] received_checksum;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  int mismatches;
  int outstanding;
  int payload_checked;
  int frames_checked;

  // Sender's copy of the registers, only used to compute the checksum that frames carry
  logic       shadow_en  = 1'b1;
  logic [7:0] shadow_val = 8'h00;

  // calm: a stretch with no random idling on either side
  bit calm;
  bit hold_off_req;
  int hold_offs;
  int bytes_sent;
  int frames_sent;
  int bad_frames;
  int long_frames;
  int cfg_writes;

  telemetry_frame_checker u_top (.*);

  tfc_result_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bitwise reflected CRC-16, poly 0x8408 (X.25 update, one byte)
  function automatic logic [15:0] x25_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
    end
    return r;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long pause
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] fill_byte(input fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  // Offer one item; valid stays up until accepted, then maybe drop for a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid  <= 1'b1;
    data_byte <= b;
    do begin
      @(posedge clk);
    end while (!in_ready);
    bytes_sent++;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and let every queued result drain out of the block
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_EXTRA_ENABLE) shadow_en = value[0];
    else shadow_val = value;
    cfg_writes++;
  endtask

  // One complete frame. The checksum is folded as bytes go out, so a register
  // change in the middle (retune_mid) is picked up at the frame end like in the block.
  task automatic send_frame(input int len, input fill_t fill, input bit bad_sum,
                            input bit retune_mid);
    logic [15:0] running_crc;
    logic [7:0]  b;
    running_crc = CRC_INIT;
    send_byte(fill_byte(fill));               // header, not part of the checksum
    send_byte(8'(len));
    running_crc = x25_next(running_crc, 8'(len));
    repeat (4) begin                          // sequence, system, component, message
      b = fill_byte(fill);
      send_byte(b);
      running_crc = x25_next(running_crc, b);
    end
    if (retune_mid) begin
      write_reg(CFG_EXTRA_ENABLE, 8'($urandom));
      write_reg(CFG_EXTRA_VALUE, 8'($urandom));
    end
    for (int i = 0; i < len; i++) begin
      b = fill_byte(fill);
      send_byte(b);
      running_crc = x25_next(running_crc, b);
    end
    if (shadow_en) running_crc = x25_next(running_crc, shadow_val);
    if (bad_sum) begin
      running_crc ^= 16'($urandom_range(1, 65535));
      bad_frames++;
    end
    send_byte(running_crc[7:0]);              // low byte first
    send_byte(running_crc[15:8]);
    frames_sent++;
    if (len == 255) long_frames++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
        hold_offs++;
      end else if (stall == 0 && !calm) begin
        stall = idle_len();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #WATCHDOG_NS;
    $display("TIMEOUT: stream did not complete");
    $display("telemetry_frame_checker test failed");
    $finish;
  end

  initial begin
    int    len;
    int    r;
    int    k;
    fill_t fill;
    bit    hold_done;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_EXTRA_ENABLE;
    cfg_data  <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed frames, reset config first (extra byte 0x00 folded in) ----
    // zero length: checksum right after message id; all-zero and all-ones fields
    send_frame(0, FILL_ZERO, 1'b0, 1'b0);
    send_frame(0, FILL_ONES, 1'b0, 1'b0);
    // payload byte extremes
    send_frame(2, FILL_ZERO, 1'b0, 1'b0);
    send_frame(2, FILL_ONES, 1'b0, 1'b0);
    // corrupted checksum must flag a miss
    send_frame(3, FILL_RANDOM, 1'b1, 1'b0);
    // top extra byte value
    write_reg(CFG_EXTRA_VALUE, 8'hFF);
    send_frame(1, FILL_RANDOM, 1'b0, 1'b0);
    // extra byte off; upper data bits should be ignored
    write_reg(CFG_EXTRA_ENABLE, 8'hFE);
    send_frame(4, FILL_RANDOM, 1'b0, 1'b0);
    send_frame(1, FILL_RANDOM, 1'b1, 1'b0);
    // registers change in the middle of a frame
    send_frame(3, FILL_RANDOM, 1'b0, 1'b1);
    write_reg(CFG_EXTRA_ENABLE, 8'h01);
    write_reg(CFG_EXTRA_VALUE, 8'h00);

    // ---- random frames ----
    // Streams are kept frame-aligned so checksum/length content goes deep;
    // bad checksums, odd fills and config changes are the noise.
    k = 0;
    hold_done = 1'b0;
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) calm = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0: write_reg(CFG_EXTRA_ENABLE, 8'($urandom));
          1: write_reg(CFG_EXTRA_VALUE, 8'($urandom));
          default: write_reg(CFG_EXTRA_VALUE, $urandom_range(0, 1) ? 8'hFF : 8'h00);
        endcase
      end

      // one long receiver hold-off while the sender keeps pushing
      if (!hold_done && k == 30) begin
        calm         = 1'b1;
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end

      // mostly short frames; two at the maximum length reach the top index bits
      r = $urandom_range(0, 99);
      if (k == 25 || k == 55) len = 255;
      else if (r < 10) len = $urandom_range(17, 80);
      else len = $urandom_range(0, 16);

      r = $urandom_range(0, 99);
      if (r < 3) fill = FILL_ZERO;
      else if (r < 6) fill = FILL_ONES;
      else fill = FILL_RANDOM;

      // no mid-frame register write while the hold-off frame is going out
      send_frame(len, fill, $urandom_range(0, 4) == 0,
                 k != 30 && $urandom_range(0, 19) == 0);
      k++;
    end

    settle();

    $display("Run: %0d bytes in %0d frames (%0d bad checksum, %0d max length), %0d reg writes",
             bytes_sent, frames_sent, bad_frames, long_frames, cfg_writes);
    $display("Checked %0d payload items and %0d frame-end items, %0d long receiver hold-off",
             payload_checked, frames_checked, hold_offs);
    if (mismatches == 0 && outstanding == 0) begin
      $display("telemetry_frame_checker test passed");
    end else begin
      $display("telemetry_frame_checker test failed");
    end
    $finish;
  end

endmodule
